// ===== hdl/kepler_equation_solver_macros.svh =====
// Assertion macros used by the checker
`ifndef KEPLER_EQUATION_SOLVER_MACROS_SVH
`define KEPLER_EQUATION_SOLVER_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during rst
`define KES_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kes assertion failed");

// Next-cycle implication, sampled on clk, held off during rst
`define KES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kes assertion failed");

`endif

// ===== hdl/kes_pkg.sv =====
package kes_pkg;

  localparam int IQ            = 59;
  localparam int CORDIC_STEPS  = 48;
  localparam int CW            = 62;
  localparam int TOL_WIDTH     = 21;
  localparam int ECC_WIDTH     = 24;
  localparam int MAX_STEPS_DEF = 10;
  localparam int ANGLE_WIDTH_DEF = 32;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 21'd268;

  typedef logic signed [63:0] rom_t [CORDIC_STEPS];

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_FOLD,
    ST_ROT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_ROUND,
    ST_RESID,
    ST_DERIV,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } state_t;

  function automatic longint unsigned cdiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] pi_q61();
    longint unsigned p;
    longint unsigned t;
    longint signed s5;
    longint signed s239;
    longint unsigned k;
    s5 = 0;
    k = 0;
    p = (64'd1 << 61) / 64'd5;
    while (p != 0) begin
      t = cdiv(p, 2 * k + 1);
      s5 = k[0] ? s5 - longint'(t) : s5 + longint'(t);
      p = p / 64'd25;
      k = k + 1;
    end
    s239 = 0;
    k = 0;
    p = (64'd1 << 61) / 64'd239;
    while (p != 0) begin
      t = cdiv(p, 2 * k + 1);
      s239 = k[0] ? s239 - longint'(t) : s239 + longint'(t);
      p = p / 64'd57121;
      k = k + 1;
    end
    return 4 * s5 - s239;
  endfunction

  function automatic logic signed [63:0] atan_entry(int i);
    longint signed sum;
    longint unsigned t;
    longint unsigned k;
    sum = 0;
    k = 0;
    if (i == 0) begin
      return (pi_q61() + 2) >>> 2;
    end
    while (longint'(i) * (2 * k + 1) <= 61) begin
      t = cdiv((64'd1 << 61) >> (longint'(i) * (2 * k + 1)), 2 * k + 1);
      sum = k[0] ? sum - longint'(t) : sum + longint'(t);
      k = k + 1;
    end
    return (sum + 2) >>> 2;
  endfunction

  function automatic rom_t atan_table();
    rom_t t;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      t[i] = atan_entry(i);
    end
    return t;
  endfunction

  localparam rom_t ATAN_ROM = atan_table();
  localparam logic signed [63:0] PI_Q59 = pi_q61();
  localparam logic signed [63:0] HALF_PI_Q59 = PI_Q59 >>> 1;

  function automatic logic signed [63:0] gain_q59();
    longint signed x;
    longint signed y;
    longint signed z;
    longint signed xs;
    longint signed ys;
    longint unsigned q;
    longint unsigned r;
    longint unsigned g;
    x = longint'(64'd1 << IQ);
    y = 0;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_entry(i);
      end else begin
        x = x + ys; y = y - xs; z = z + atan_entry(i);
      end
    end
    g = longint'(x);
    q = 0;
    r = 64'd1 << IQ;
    for (int i = 0; i < IQ; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= g) begin
        r = r - g;
        q = q | 64'd1;
      end
    end
    return longint'(q);
  endfunction

  localparam logic signed [63:0] GAIN_Q59 = gain_q59();

endpackage

// ===== hdl/kepler_equation_solver.sv =====
// Each Newton step runs a 48-step CORDIC, a split eccentricity multiply and a restoring
// divide, for up to MAX_STEPS steps; a solve that converges ends on its residual check.
// Throughput: one word in flight; a new word is taken once the previous result is
// latched into the output register. Reset idles the sequencer, clears m_tvalid
// and reloads the default tolerance.
module kepler_equation_solver #(
  parameter int ANGLE_WIDTH = kes_pkg::ANGLE_WIDTH_DEF,
  parameter int MAX_STEPS   = kes_pkg::MAX_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // mean_anomaly, eccentricity
  input  logic [((ANGLE_WIDTH+31)/8)*8-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // eccentric_anomaly, steps_used, converged
  output logic [((ANGLE_WIDTH+12)/8)*8-1:0]   m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kes_pkg::TOL_WIDTH-1:0]       cfg_data
);

  localparam int AW    = ANGLE_WIDTH;
  localparam int AF    = AW - 4;
  localparam int SH    = kes_pkg::IQ - AF;
  localparam int CW    = kes_pkg::CW;
  localparam int HW    = CW / 2;
  localparam int EW    = kes_pkg::ECC_WIDTH;
  localparam int OUT_W = ((AW + 12) / 8) * 8;
  localparam int SW    = $clog2(MAX_STEPS + 1);
  localparam int NW    = AW + 1 + AF;
  localparam logic signed [AW:0]   D_ONE = (AW + 1)'(1) <<< AF;
  localparam logic signed [AW+1:0] A_MAX = (AW + 2)'((64'sd1 <<< (AW - 1)) - 1);
  localparam logic signed [AW+1:0] A_MIN = -(AW + 2)'(64'sd1 <<< (AW - 1));

  kes_pkg::state_t state, state_next;

  logic [kes_pkg::TOL_WIDTH-1:0] tol;
  logic signed [AW-1:0] m_ang, e_ang, ta;
  logic [EW-1:0]        ecc;
  logic signed [63:0]   z;
  logic                 flip, sel_cos, neg, conv;
  logic signed [CW-1:0] sin_v, cos_v;
  logic [HW+EW-1:0]     plo, phi;
  logic [CW-1:0]        r_mag;
  logic signed [AW+1:0] f;
  logic [AW:0]          fmag;
  logic [SW-1:0]        steps;
  logic [OUT_W-1:0]     out_data;

  logic cordic_start, cordic_done, div_start, div_done, s_acc, out_load;
  logic signed [CW-1:0] c_cos, c_sin;
  logic [AW:0]          quo;

  logic signed [63:0]   z_in, z_wrap, z_fold;
  logic                 fold_flip;
  logic signed [CW-1:0] opv;
  logic [CW-1:0]        mag;
  logic [HW-1:0]        mul_a;
  logic [HW+EW-1:0]     prod;
  logic [HW+EW+HW:0]    r_sum;
  logic signed [63:0]   sv, sv_rnd;
  logic signed [AW-1:0] ta_calc;
  logic signed [AW+1:0] f_calc;
  logic [AW:0]          fmag_calc;
  logic                 below_tol;
  logic signed [AW:0]   dtmp;
  logic [AW-1:0]        d_calc;
  logic signed [AW+1:0] e_sum;
  logic signed [AW-1:0] e_sat;
  logic [SW-1:0]        steps_inc;

  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid & s_tready;
  assign out_load  = (state == kes_pkg::ST_DONE) & (!m_tvalid | m_tready);
  assign m_tdata   = out_data;

  assign z_in = 64'(e_ang) <<< SH;
  always_comb begin
    z_wrap = z_in;
    if (z_in > kes_pkg::PI_Q59) begin
      z_wrap = z_in - 2 * kes_pkg::PI_Q59;
    end else if (z_in < -kes_pkg::PI_Q59) begin
      z_wrap = z_in + 2 * kes_pkg::PI_Q59;
    end
  end

  always_comb begin
    z_fold    = z;
    fold_flip = 1'b0;
    if (z > kes_pkg::HALF_PI_Q59) begin
      z_fold    = z - kes_pkg::PI_Q59;
      fold_flip = 1'b1;
    end else if (z < -kes_pkg::HALF_PI_Q59) begin
      z_fold    = z + kes_pkg::PI_Q59;
      fold_flip = 1'b1;
    end
  end

  assign opv   = sel_cos ? cos_v : sin_v;
  assign mag   = opv[CW-1] ? CW'(-opv) : CW'(opv);
  assign mul_a = (state == kes_pkg::ST_MUL_LO) ? mag[HW-1:0] : mag[CW-1:HW];
  assign prod  = mul_a * ecc;
  assign r_sum = {phi, {HW{1'b0}}} + (HW + EW + HW + 1)'(plo);

  assign sv      = neg ? -$signed(64'(r_mag)) : $signed(64'(r_mag));
  assign sv_rnd  = sv + (64'sd1 <<< (SH - 1));
  assign ta_calc = AW'(sv_rnd >>> SH);

  assign f_calc    = (AW + 2)'(e_ang) - (AW + 2)'(m_ang) - (AW + 2)'(ta);
  assign fmag_calc = f_calc[AW+1] ? (AW + 1)'(-f_calc) : (AW + 1)'(f_calc);
  assign below_tol = 64'(fmag_calc) < 64'(tol);

  assign dtmp   = D_ONE - (AW + 1)'(ta);
  assign d_calc = (dtmp < $signed((AW + 1)'(1))) ? AW'(1) : dtmp[AW-1:0];

  assign e_sum = f[AW+1] ? (AW + 2)'(e_ang) + $signed((AW + 2)'(quo))
                         : (AW + 2)'(e_ang) - $signed((AW + 2)'(quo));
  assign e_sat = (e_sum > A_MAX) ? AW'(A_MAX) : (e_sum < A_MIN) ? AW'(A_MIN) : AW'(e_sum);
  assign steps_inc = steps + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      kes_pkg::ST_IDLE:    if (s_acc) state_next = kes_pkg::ST_WRAP;
      kes_pkg::ST_WRAP:    state_next = kes_pkg::ST_FOLD;
      kes_pkg::ST_FOLD:    state_next = kes_pkg::ST_ROT;
      kes_pkg::ST_ROT:     if (cordic_done) state_next = kes_pkg::ST_MUL_LO;
      kes_pkg::ST_MUL_LO:  state_next = kes_pkg::ST_MUL_HI;
      kes_pkg::ST_MUL_HI:  state_next = kes_pkg::ST_MUL_SUM;
      kes_pkg::ST_MUL_SUM: state_next = kes_pkg::ST_ROUND;
      kes_pkg::ST_ROUND:   state_next = sel_cos ? kes_pkg::ST_DERIV : kes_pkg::ST_RESID;
      kes_pkg::ST_RESID:   state_next = below_tol ? kes_pkg::ST_DONE : kes_pkg::ST_MUL_LO;
      kes_pkg::ST_DERIV:   state_next = kes_pkg::ST_DIV;
      kes_pkg::ST_DIV:     if (div_done) state_next = kes_pkg::ST_UPDATE;
      kes_pkg::ST_UPDATE: begin
        state_next = (steps_inc == SW'(MAX_STEPS)) ? kes_pkg::ST_DONE : kes_pkg::ST_WRAP;
      end
      kes_pkg::ST_DONE:    if (out_load) state_next = kes_pkg::ST_IDLE;
      default:             state_next = kes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    cordic_start = 1'b0;
    div_start    = 1'b0;
    case (state)
      kes_pkg::ST_IDLE:  s_tready = 1'b1;
      kes_pkg::ST_FOLD:  cordic_start = 1'b1;
      kes_pkg::ST_DERIV: div_start = 1'b1;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kes_pkg::ST_IDLE;
      tol      <= kes_pkg::TOL_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        tol <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      kes_pkg::ST_IDLE: begin
        m_ang <= s_tdata[AW-1:0];
        e_ang <= s_tdata[AW-1:0];
        ecc   <= s_tdata[AW+EW-1:AW];
        steps <= '0;
        conv  <= 1'b0;
      end
      kes_pkg::ST_WRAP: begin
        z       <= z_wrap;
        sel_cos <= 1'b0;
      end
      kes_pkg::ST_FOLD:  flip <= fold_flip;
      kes_pkg::ST_ROT: begin
        sin_v <= flip ? -c_sin : c_sin;
        cos_v <= flip ? -c_cos : c_cos;
      end
      kes_pkg::ST_MUL_LO: begin
        plo <= prod;
        neg <= opv[CW-1];
      end
      kes_pkg::ST_MUL_HI:  phi <= prod;
      kes_pkg::ST_MUL_SUM: r_mag <= CW'(r_sum >> EW);
      kes_pkg::ST_ROUND:   ta <= ta_calc;
      kes_pkg::ST_RESID: begin
        f       <= f_calc;
        fmag    <= fmag_calc;
        sel_cos <= 1'b1;
        if (below_tol) begin
          conv <= 1'b1;
        end
      end
      kes_pkg::ST_UPDATE: begin
        e_ang <= e_sat;
        steps <= steps_inc;
      end
      kes_pkg::ST_DONE: begin
        if (out_load) begin
          out_data <= OUT_W'({conv, 4'(steps), e_ang});
        end
      end
      default: begin
      end
    endcase
  end

  kes_cordic #(
    .CW    (CW),
    .STEPS (kes_pkg::CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .z0      (CW'(z_fold)),
    .done    (cordic_done),
    .cos_out (c_cos),
    .sin_out (c_sin)
  );

  kes_divider #(
    .NW (NW),
    .DW (AW),
    .QW (AW + 1)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({fmag, {AF{1'b0}}}),
    .den   (d_calc),
    .done  (div_done),
    .quo   (quo)
  );

endmodule

// ===== hdl/kes_cordic.sv =====
module kes_cordic #(
  parameter int CW    = kes_pkg::CW,
  parameter int STEPS = kes_pkg::CORDIC_STEPS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] z0,
  output logic                 done,
  output logic signed [CW-1:0] cos_out,
  output logic signed [CW-1:0] sin_out
);

  localparam int IW = $clog2(STEPS);

  logic          busy;
  logic [IW-1:0] idx;
  logic signed [CW-1:0] x, y, z;
  logic signed [CW-1:0] xs, ys, at;

  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = CW'(kes_pkg::ATAN_ROM[idx]);
  assign cos_out = x;
  assign sin_out = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        if (idx == IW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CW'(kes_pkg::GAIN_Q59);
      y <= '0;
      z <= z0;
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - ys; y <= y + xs; z <= z - at;
      end else begin
        x <= x + ys; y <= y - xs; z <= z + at;
      end
    end
  end

endmodule

// ===== hdl/kes_divider.sv =====
module kes_divider #(
  parameter int NW = 61,
  parameter int DW = 32,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CNW = $clog2(NW + 1);

  logic           busy;
  logic           sat;
  logic [CNW-1:0] cnt;
  logic [NW-1:0]  nsh;
  logic [DW-1:0]  dv;
  logic [DW-1:0]  rem;
  logic [QW-1:0]  q;
  logic [DW:0]    r2;
  logic           ge;
  logic [QW-1:0]  q_next;
  logic           sat_next;

  assign r2       = {rem, nsh[NW-1]};
  assign ge       = r2 >= {1'b0, dv};
  assign q_next   = {q[QW-2:0], ge};
  assign sat_next = sat | q[QW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= num;
      dv  <= den;
      rem <= '0;
      q   <= '0;
      sat <= 1'b0;
    end else if (busy) begin
      nsh <= nsh << 1;
      rem <= ge ? DW'(r2 - {1'b0, dv}) : DW'(r2);
      q   <= q_next;
      sat <= sat_next;
      if (cnt == CNW'(NW - 1)) begin
        quo <= (sat_next | q_next[QW-1]) ? (QW'(1) << (QW - 1)) : q_next;
      end
    end
  end

endmodule

// ===== hdl/kes_checker.sv =====
`include "kepler_equation_solver_macros.svh"

module kes_checker #(
  parameter int ANGLE_WIDTH = kes_pkg::ANGLE_WIDTH_DEF,
  parameter int MAX_STEPS   = kes_pkg::MAX_STEPS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [((ANGLE_WIDTH+31)/8)*8-1:0] s_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((ANGLE_WIDTH+12)/8)*8-1:0] m_tdata,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [kes_pkg::TOL_WIDTH-1:0]     cfg_data
);

  localparam int AW = ANGLE_WIDTH;

  // s_tready drops once a word is taken
  `KES_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

  // a result that gave up reports the full step budget
  `KES_ASSERT_NOW(a_limit_steps, m_tvalid && !m_tdata[AW+4], m_tdata[AW+3:AW] == 4'(MAX_STEPS))

  // hold a stalled result word
  `KES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind kepler_equation_solver kes_checker #(
  .ANGLE_WIDTH (ANGLE_WIDTH),
  .MAX_STEPS   (MAX_STEPS)
) u_kes_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int AW = 32;
  localparam int FR = AW - 4;
  localparam int NSTEP = 10;
  localparam int CSTEPS = 48;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_LEN = 3000;
  localparam int TOL_MAX = 1048576;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;     // mean_anomaly[31:0], eccentricity[55:32]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;          // eccentric_anomaly[31:0], steps_used[35:32], converged[36]
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kes_pkg::TOL_WIDTH-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  kepler_equation_solver u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  longint atan_tab [CSTEPS];
  longint pi_fix;
  longint gain_fix;
  longint unsigned tolerance;

  logic [55:0] pend_words [$];
  logic [39:0] solution_q [$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  function automatic longint unsigned div_sat(longint unsigned n, longint unsigned d, int sh,
                                              longint unsigned lim);
    longint unsigned q, r;
    if (d == 0) return lim;
    q = n / d;
    r = n % d;
    for (int i = 0; i < sh; i++) begin
      if (q >= lim) return lim;
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return (q >= lim) ? lim : q;
  endfunction

  function automatic longint atan_inv(longint unsigned x);
    longint unsigned p, k;
    longint sum, t;
    p = (64'd1 << 61) / x;
    sum = 0;
    k = 0;
    while (p != 0) begin
      t = longint'(p / (2 * k + 1));
      sum = k[0] ? sum - t : sum + t;
      p = p / (x * x);
      k++;
    end
    return sum;
  endfunction

  function automatic void rotate(longint x, longint z, output longint c, output longint s);
    longint y, xs, ys;
    y = 0;
    for (int i = 0; i < CSTEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic void build_tables();
    longint p4, sum, t, g, dmy;
    longint unsigned k;
    p4 = 4 * atan_inv(5) - atan_inv(239);
    pi_fix = p4;
    atan_tab[0] = (p4 + 2) >>> 2;
    for (int i = 1; i < CSTEPS; i++) begin
      sum = 0;
      k = 0;
      while (longint'(i) * (2 * k + 1) <= 61) begin
        t = longint'(((64'd1 << 61) >> (longint'(i) * (2 * k + 1))) / (2 * k + 1));
        sum = k[0] ? sum - t : sum + t;
        k++;
      end
      atan_tab[i] = (sum + 2) >>> 2;
    end
    rotate(longint'(64'd1 << 59), 0, g, dmy);
    gain_fix = longint'(div_sat(64'd1 << 59, longint'(g), 59, 64'd1 << 62));
  endfunction

  function automatic void sin_cos(longint ang, output longint s, output longint c);
    longint z, half;
    bit flip;
    z = ang * (longint'(1) << (59 - FR));
    half = pi_fix / 2;
    flip = 0;
    if (z > pi_fix) z = z - 2 * pi_fix;
    else if (z < -pi_fix) z = z + 2 * pi_fix;
    if (z > half) begin
      z = z - pi_fix; flip = 1;
    end else if (z < -half) begin
      z = z + pi_fix; flip = 1;
    end
    rotate(gain_fix, z, c, s);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic longint ecc_scale(longint v, longint unsigned e);
    longint unsigned m, r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = (m >> 24) * e + (((m & 64'hFFFFFF) * e) >> 24);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint round_angle(longint v);
    return (v + (longint'(1) << (59 - FR - 1))) >>> (59 - FR);
  endfunction

  function automatic logic [39:0] solve_kepler(logic [55:0] w);
    longint amax, amin, m, ea, sn, cs, f, d, q;
    longint unsigned ecc, fmag;
    logic [3:0] steps;
    logic conv;
    amax = (longint'(1) << (AW - 1)) - 1;
    amin = -amax - 1;
    m = longint'($signed(w[31:0]));
    ecc = longint'(w[55:32]);
    ea = m;
    steps = 0;
    conv = 0;
    for (int it = 0; it < NSTEP; it++) begin
      sin_cos(ea, sn, cs);
      f = ea - m - round_angle(ecc_scale(sn, ecc));
      fmag = (f < 0) ? longint'(-f) : longint'(f);
      if (fmag < tolerance) begin
        conv = 1;
        break;
      end
      d = (longint'(1) << FR) - round_angle(ecc_scale(cs, ecc));
      if (d < 1) d = 1;
      q = longint'(div_sat(fmag, d, FR, 64'd1 << AW));
      ea = (f < 0) ? ea + q : ea - q;
      if (ea > amax) ea = amax;
      if (ea < amin) ea = amin;
      steps++;
    end
    return {3'b000, conv, steps, ea[31:0]};
  endfunction

  // driver
  int gap_left = 0;
  int burst_left = 4;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        solution_q.push_back(solve_kepler(pend_words.pop_front()));
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pend_words.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= pend_words[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and one long hold-off
  int hold_left = 0;
  bit hold_done = 0;
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && results_seen == 120) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 400);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 0);
          2: m_tready <= ($urandom_range(0, 7) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [39:0] want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = solution_q.pop_front();
        if (m_tdata[31:0] !== want[31:0]) begin
          $display("%0t: eccentric_anomaly expected %h actual %h", $time, want[31:0],
                   m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[35:32] !== want[35:32]) begin
          $display("%0t: steps_used expected %0d actual %0d", $time, want[35:32],
                   m_tdata[35:32]);
          errors++;
        end
        if (m_tdata[36] !== want[36]) begin
          $display("%0t: converged expected %b actual %b", $time, want[36], m_tdata[36]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_tolerance(int unsigned v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v[kes_pkg::TOL_WIDTH-1:0];
    do @(posedge clk); while (!cfg_ready);
    tolerance = v & ((1 << kes_pkg::TOL_WIDTH) - 1);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pend_words.size() > 0 || solution_q.size() > 0) @(posedge clk);
  endtask

  function automatic logic [55:0] mk(logic [31:0] ma, logic [23:0] e);
    return {e, ma};
  endfunction

  function automatic logic [55:0] random_word();
    logic [31:0] ma;
    logic [23:0] e;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) ma = 32'($signed($urandom_range(0, 1686629714)) - 843314857);
    else ma = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 4) e = 24'($urandom);
    else if (sel < 7) e = 24'($urandom_range(0, 24'h3FFFFF));
    else e = 24'hFFFFFF - 24'($urandom_range(0, 4095));
    return mk(ma, e);
  endfunction

  initial begin
    int unsigned tols [5];
    build_tables();
    tolerance = 268;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    pend_words.push_back(mk(32'h0, 24'h0));
    pend_words.push_back(mk(32'h0, 24'hFFFFFF));
    pend_words.push_back(mk(32'h7FFFFFFF, 24'h0));
    pend_words.push_back(mk(32'h7FFFFFFF, 24'hFFFFFF));
    pend_words.push_back(mk(32'h80000000, 24'hFFFFFF));
    pend_words.push_back(mk(32'h80000000, 24'h800000));
    pend_words.push_back(mk(32'd843314857, 24'hFFFFFF));
    pend_words.push_back(mk(-32'sd843314857, 24'hFFFFFF));
    pend_words.push_back(mk(32'd421657428, 24'hC00000));
    pend_words.push_back(mk(-32'sd421657428, 24'hFFFFFF));
    pend_words.push_back(mk(32'd1, 24'hFFFFFF));
    pend_words.push_back(mk(32'hFFFFFFFF, 24'hFFFFFE));
    pend_words.push_back(mk(32'h55555555, 24'hAAAAAA));
    pend_words.push_back(mk(32'hAAAAAAAA, 24'h555555));
    drain();

    tols[0] = 0;
    tols[1] = TOL_MAX;
    tols[2] = 1;
    tols[3] = $urandom_range(2, TOL_MAX);
    tols[4] = 268;
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tols[ph]);
      pend_words.push_back(mk(32'h0, 24'hFFFFFF));
      pend_words.push_back(mk(32'h7FFFFFFF, 24'hFFFFFF));
      for (int i = 0; i < 165; i++) pend_words.push_back(random_word());
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
